// ===== hw/rtl/hcea_pkg.sv =====
// shared types, constants and helpers for the hebbian context error augment block
`timescale 1ns / 1ps
`default_nettype none

package hcea_pkg;

	localparam int CTX_N     = 8;
	localparam int FRAC_BITS = 12;
	localparam int DW        = 16;
	localparam int SEL_W     = (CTX_N > 1) ? $clog2(CTX_N) : 1;
	localparam int OPW       = 2 * DW + 1 - FRAC_BITS;
	localparam int PW        = 2 * OPW;
	localparam int ACCW      = 36;
	localparam int SATW      = 40;
	localparam int LR_SHIFT  = 16;
	localparam int FLOOR_W   = 13;
	localparam int IN_W      = (2 + CTX_N) * DW;

	localparam logic [DW-1:0]      LEARN_RESET = 16'd197;
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 13'd614;

	localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(CTX_N - 1);

	typedef enum logic [1:0] {
		CFG_LEARN_RATE   = 2'd0,
		CFG_SENSOR_FLOOR = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		PH_SQ,
		PH_ES,
		PH_LR,
		PH_DP,
		PH_WS
	} phase_t;

	typedef struct packed {
		logic             load;
		logic             step;
		phase_t           phase;
		logic [SEL_W-1:0] sel;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		logic out_free;
	} stat_t;

	function automatic logic signed [DW-1:0] sat16(input logic signed [SATW-1:0] x);
		logic signed [DW-1:0] r;
		if (x > SATW'(32767)) begin
			r = 16'sh7fff;
		end else if (x < -SATW'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = x[DW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hebbian_context_error_augment.sv =====
// top level: config registers, sensor capture, two channel lanes and result register
`timescale 1ns / 1ps
`default_nettype none

// Augments two channel errors with a learned context term. Each accepted beat
// zeroes context sensors below sensor_floor, moves every weight of both channels
// by learn_rate*error*sensor*(1-w^2) and returns each error plus its channel's
// dot product of the updated weights with the sensors, all saturated Q3.12.
// Weights reset to zero. Each lane runs its single multiplier through five
// phases per sensor (w*w, error*sensor, times rate, times (1-w^2), new weight*sensor)
// over eight sensors, both channels in parallel, with a load step before and an
// unload step after. No new item is accepted until the previous one is unloaded.
// The result register lets a new item be accepted while a result waits.
// Config writes are taken at any time but must only occur while idle.

module hebbian_context_error_augment
	import hcea_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	// error_first, error_second, ctx_0 .. ctx_7 (16 bits each)
	input  wire logic [IN_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	// augmented_first, augmented_second (16 bits each)
	output logic [2*DW-1:0]      m_tdata,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [DW-1:0]   cfg_data
);

	logic [DW-1:0]        learn_rate_q;
	logic [FLOOR_W-1:0]   sensor_floor_q;
	logic signed [DW-1:0] sens_q [CTX_N];
	logic                 m_tvalid_q;
	logic [2*DW-1:0]      m_tdata_q;

	stat_t                stat;
	cmd_t                 cmd;
	logic                 busy;
	logic signed [DW-1:0] aug0, aug1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q   <= LEARN_RESET;
			sensor_floor_q <= FLOOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEARN_RATE:   learn_rate_q   <= cfg_data;
				CFG_SENSOR_FLOOR: sensor_floor_q <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready      = !busy;
	assign stat.in_fire  = s_tvalid && s_tready;
	assign stat.out_free = !m_tvalid_q || m_tready;

	// floor compare in signed 17 bits: negative sensors always fall below
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < CTX_N; i++) begin
				if ($signed({s_tdata[(2 + i) * DW + DW - 1], s_tdata[(2 + i) * DW +: DW]})
						< $signed({4'b0000, sensor_floor_q})) begin
					sens_q[i] <= '0;
				end else begin
					sens_q[i] <= s_tdata[(2 + i) * DW +: DW];
				end
			end
		end
	end

	hcea_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	hcea_lane u_lane0 (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.err_in     (s_tdata[DW-1:0]),
		.sens       (sens_q[cmd.sel]),
		.learn_rate (learn_rate_q),
		.aug        (aug0)
	);

	hcea_lane u_lane1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.err_in     (s_tdata[2*DW-1:DW]),
		.sens       (sens_q[cmd.sel]),
		.learn_rate (learn_rate_q),
		.aug        (aug1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_tdata_q <= {aug1, aug0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		stat.in_fire |=> !s_tready)
		else $error("input accepted again while an item is in flight");

	a_no_step_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !s_tready)
		else $error("datapath stepping while input is open");

	a_finish_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken result");

	a_result_follows_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !$past(cmd.load))
		else $error("result delivered without running the sensor sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/hcea_ctrl.sv =====
// sequencer stepping both lanes through five multiply phases per sensor
`timescale 1ns / 1ps
`default_nettype none

module hcea_ctrl
	import hcea_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output logic       busy,
	output cmd_t       cmd
);

	state_t           state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [SEL_W-1:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SQ;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		sel_d      = sel_q;
		busy       = 1'b1;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.phase  = phase_q;
		cmd.sel    = sel_q;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (stat.in_fire) begin
					cmd.load = 1'b1;
					phase_d  = PH_SQ;
					sel_d    = '0;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				unique case (phase_q)
					PH_SQ: phase_d = PH_ES;
					PH_ES: phase_d = PH_LR;
					PH_LR: phase_d = PH_DP;
					PH_DP: phase_d = PH_WS;
					PH_WS: begin
						phase_d = PH_SQ;
						if (sel_q == SEL_LAST) begin
							state_d = ST_DONE;
						end else begin
							sel_d = sel_q + SEL_W'(1);
						end
					end
					default: phase_d = PH_SQ;
				endcase
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hcea_lane.sv =====
// one channel: weight bank, shared multiplier and accumulator
`timescale 1ns / 1ps
`default_nettype none

module hcea_lane
	import hcea_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic signed [DW-1:0] err_in,
	input  wire logic signed [DW-1:0] sens,
	input  wire logic [DW-1:0]        learn_rate,
	output logic signed [DW-1:0]      aug
);

	localparam logic signed [PW-1:0]     HALF_F  = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PW-1:0]     HALF_L  = PW'(1) <<< (LR_SHIFT - 1);
	localparam logic signed [PW-1:0]     ONE_F   = PW'(1) <<< FRAC_BITS;
	localparam logic signed [ACCW:0]     HALF_A  = (ACCW + 1)'(1) <<< (FRAC_BITS - 1);

	logic signed [DW-1:0]   w_q [CTX_N];
	logic signed [DW-1:0]   err_q;
	logic signed [DW-1:0]   wn_q;
	logic signed [OPW-1:0]  om_q, t1_q, t2_q;
	logic signed [ACCW-1:0] acc_q;

	logic signed [DW-1:0]   w_cur;
	logic signed [OPW-1:0]  opa, opb;
	logic signed [PW-1:0]   prod;
	logic signed [PW-1:0]   rnd_f, rnd_l;
	logic signed [DW-1:0]   wn;
	logic signed [ACCW:0]   acc_rnd;

	assign w_cur = w_q[cmd.sel];

	always_comb begin
		opa = OPW'(w_cur);
		opb = OPW'(w_cur);
		unique case (cmd.phase)
			PH_SQ: begin
				opa = OPW'(w_cur);
				opb = OPW'(w_cur);
			end
			PH_ES: begin
				opa = OPW'(err_q);
				opb = OPW'(sens);
			end
			PH_LR: begin
				opa = t1_q;
				opb = $signed({{(OPW - DW){1'b0}}, learn_rate});
			end
			PH_DP: begin
				opa = t2_q;
				opb = om_q;
			end
			PH_WS: begin
				opa = OPW'(wn_q);
				opb = OPW'(sens);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod  = opa * opb;
	assign rnd_f = (prod + HALF_F) >>> FRAC_BITS;
	assign rnd_l = (prod + HALF_L) >>> LR_SHIFT;
	assign wn    = sat16(SATW'(w_cur) + SATW'(rnd_f));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CTX_N; i++) begin
				w_q[i] <= '0;
			end
		end else if (cmd.step && cmd.phase == PH_DP) begin
			w_q[cmd.sel] <= wn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= err_in;
			acc_q <= ACCW'(err_in) <<< FRAC_BITS;
		end else if (cmd.step) begin
			unique case (cmd.phase)
				PH_SQ:   om_q  <= OPW'(ONE_F - rnd_f);
				PH_ES:   t1_q  <= rnd_f[OPW-1:0];
				PH_LR:   t2_q  <= rnd_l[OPW-1:0];
				PH_DP:   wn_q  <= wn;
				PH_WS:   acc_q <= acc_q + ACCW'(prod);
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign acc_rnd = ((ACCW + 1)'(acc_q) + HALF_A) >>> FRAC_BITS;
	assign aug     = sat16(SATW'(acc_rnd));

endmodule

`default_nettype wire

// ===== bench/tb_hebbian_context_error_augment.sv =====
// self-checking bench for the hebbian context error augment block with a bit-true weight model
`timescale 1ns / 1ps

module tb_hebbian_context_error_augment;
	import hcea_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 60;
	localparam int BANK_STRIDE   = 8;
	localparam int PHASE_ITEMS   = 64;
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	// packs as error_first in the low bits, then error_second, then ctx_0 .. ctx_7
	typedef struct packed {
		logic [CTX_N-1:0][DW-1:0] ctx;
		logic [DW-1:0]            err_second;
		logic [DW-1:0]            err_first;
	} sample_t;

	typedef struct packed {
		logic [DW-1:0] aug_second;
		logic [DW-1:0] aug_first;
	} aug_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            s_tvalid  = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata   = '0;
	logic            m_tvalid;
	logic            m_tready  = 1'b0;
	logic [2*DW-1:0] m_tdata;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [1:0]      cfg_index = '0;
	logic [DW-1:0]   cfg_data  = '0;

	sample_t              pending_samples[$];
	aug_t                 expected_augs[$];
	sample_t              sample_on_bus;
	aug_t                 aug_want;
	logic [DW-1:0]        rate_q;
	logic [FLOOR_W-1:0]   floor_q;
	logic signed [DW-1:0] weights [2*BANK_STRIDE];
	int                   samples_queued = 0;
	int                   samples_taken  = 0;
	int                   send_gap       = 0;
	int                   recv_stall     = 0;
	bit                   calm           = 1'b0;
	int                   fail_count     = 0;
	int                   cycles         = 0;

	hebbian_context_error_augment u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// round half up of x / 2^n
	function automatic longint round_shift(input longint x, input int n);
		return (x + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp16(input longint x);
		if (x > 32767) begin
			return 32767;
		end
		if (x < -32768) begin
			return -32768;
		end
		return x;
	endfunction

	// updates both weight banks and returns the augmented errors
	function automatic aug_t augment_errors(input sample_t smp);
		longint err [2];
		longint sens [CTX_N];
		longint acc, w, sq, om, t1, t2, dp, v;
		int     idx;
		aug_t   res;
		err[0] = longint'($signed(smp.err_first));
		err[1] = longint'($signed(smp.err_second));
		for (int i = 0; i < CTX_N; i++) begin
			v = longint'($signed(smp.ctx[i]));
			sens[i] = (v < longint'(floor_q)) ? 0 : v;
		end
		res = '0;
		for (int c = 0; c < 2; c++) begin
			acc = err[c] * (longint'(1) <<< FRAC_BITS);
			for (int i = 0; i < CTX_N; i++) begin
				idx = (c * BANK_STRIDE + i) % (2 * BANK_STRIDE);
				w = longint'(weights[idx]);
				sq = round_shift(w * w, FRAC_BITS);
				om = (longint'(1) <<< FRAC_BITS) - sq;
				t1 = round_shift(err[c] * sens[i], FRAC_BITS);
				t2 = round_shift(t1 * longint'(rate_q), LR_SHIFT);
				dp = round_shift(t2 * om, FRAC_BITS);
				w = clamp16(w + dp);
				weights[idx] = w[DW-1:0];
				acc += w * sens[i];
			end
			v = clamp16(round_shift(acc, FRAC_BITS));
			if (c == 0) begin
				res.aug_first = v[DW-1:0];
			end else begin
				res.aug_second = v[DW-1:0];
			end
		end
		return res;
	endfunction

	function automatic sample_t flat_sample(input logic [DW-1:0] e1, input logic [DW-1:0] e2,
			input logic [DW-1:0] cval);
		sample_t smp;
		smp.err_first = e1;
		smp.err_second = e2;
		for (int i = 0; i < CTX_N; i++) begin
			smp.ctx[i] = cval;
		end
		return smp;
	endfunction

	function automatic logic [DW-1:0] random_error();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return DW'($urandom_range(0, 255));
			default: return DW'($urandom);
		endcase
	endfunction

	// mostly usable positive sensors, some around the floor, some negative
	function automatic logic [DW-1:0] random_sensor();
		case ($urandom_range(0, 9))
			0: return DW'($urandom);
			1: return DW'(floor_q) + DW'($urandom_range(0, 3)) - 16'd2;
			2: return 16'h7fff;
			3: return '0;
			default: return DW'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		smp.err_first = random_error();
		smp.err_second = random_error();
		for (int i = 0; i < CTX_N; i++) begin
			smp.ctx[i] = random_sensor();
		end
		return smp;
	endfunction

	task automatic enqueue(input sample_t smp);
		pending_samples.push_back(smp);
		samples_queued++;
	endtask

	task automatic drain();
		while (samples_taken != samples_queued || expected_augs.size() > 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DW-1:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == CFG_LEARN_RATE) begin
			rate_q = val;
		end else if (idx == CFG_SENSOR_FLOOR) begin
			floor_q = val[FLOOR_W-1:0];
		end
	endtask

	// driver: one beat on the bus at a time, fed from the pending queue
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_augs.push_back(augment_errors(sample_on_bus));
				samples_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
					send_gap <= $urandom_range(0, 3);
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					sample_on_bus = pending_samples.pop_front();
					s_tdata <= sample_on_bus;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result beat against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_augs.size() == 0) begin
					$display("%0t: unexpected result beat, expected none got %h", $time, m_tdata);
					fail_count++;
				end else begin
					aug_want = expected_augs.pop_front();
					if (m_tdata[DW-1:0] !== aug_want.aug_first) begin
						$display("%0t: augmented_first expected %0d got %0d", $time,
							$signed(aug_want.aug_first), $signed(m_tdata[DW-1:0]));
						fail_count++;
					end
					if (m_tdata[2*DW-1:DW] !== aug_want.aug_second) begin
						$display("%0t: augmented_second expected %0d got %0d", $time,
							$signed(aug_want.aug_second), $signed(m_tdata[2*DW-1:DW]));
						fail_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				recv_stall <= $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		sample_t       smp;
		logic [DW-1:0] rate_pick;
		logic [DW-1:0] floor_pick;
		rate_q = LEARN_RESET;
		floor_q = FLOOR_RESET;
		for (int k = 0; k < 2 * BANK_STRIDE; k++) begin
			weights[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: extremes, negative sensors, sensors at and just below the floor
		enqueue(flat_sample('0, '0, '0));
		enqueue(flat_sample(16'h7fff, 16'h7fff, 16'h7fff));
		enqueue(flat_sample(16'h8000, 16'h8000, 16'h7fff));
		enqueue(flat_sample(16'h7fff, 16'h8000, 16'h8000));
		smp = flat_sample(16'h4000, 16'hc000, DW'(FLOOR_RESET));
		for (int i = 1; i < CTX_N; i += 2) begin
			smp.ctx[i] = DW'(FLOOR_RESET) - 16'd1;
		end
		enqueue(smp);
		smp = flat_sample(16'h1234, 16'hedcb, '0);
		smp.ctx[3] = 16'h0001;
		smp.ctx[5] = 16'hffff;
		enqueue(smp);
		drain();

		// full rate, no floor: drive weights into saturation and past one
		write_reg(CFG_LEARN_RATE, 16'hffff);
		write_reg(CFG_SENSOR_FLOOR, '0);
		repeat (6) enqueue(flat_sample(16'h7fff, 16'h7fff, 16'h7fff));
		repeat (4) enqueue(flat_sample(16'h8000, 16'h8000, 16'h7fff));
		smp = flat_sample(16'h7fff, 16'h8000, 16'h2000);
		for (int i = 0; i < CTX_N; i += 2) begin
			smp.ctx[i] = 16'he000;
		end
		enqueue(smp);
		drain();

		// floor written above its range, learning off
		write_reg(CFG_SENSOR_FLOOR, 16'hffff);
		write_reg(CFG_LEARN_RATE, '0);
		enqueue(flat_sample(16'h7fff, 16'h8000, 16'h1fff));
		enqueue(flat_sample(16'h8000, 16'h7fff, 16'h1ffe));
		enqueue(flat_sample(16'h0800, 16'hf800, 16'h7fff));
		drain();

		// writes to unused indexes change nothing
		write_reg(CFG_SPARE_LO, 16'h0000);
		write_reg(CFG_SPARE_HI, 16'hffff);
		enqueue(flat_sample(16'h7fff, 16'h7fff, 16'h7fff));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					rate_pick = LEARN_RESET;
					floor_pick = DW'(FLOOR_RESET);
				end
				1: begin
					rate_pick = 16'hffff;
					floor_pick = '0;
				end
				2: begin
					rate_pick = '0;
					floor_pick = 16'd4096;
				end
				3: begin
					rate_pick = 16'hffff;
					floor_pick = 16'd4096;
				end
				default: begin
					rate_pick = DW'($urandom);
					floor_pick = DW'($urandom_range(0, 4096));
				end
			endcase
			write_reg(CFG_LEARN_RATE, rate_pick);
			write_reg(CFG_SENSOR_FLOOR, floor_pick);
			calm = (ph == 5);
			repeat (PHASE_ITEMS) enqueue(random_sample());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/hcea_pkg.sv
hw/rtl/hcea_ctrl.sv
hw/rtl/hcea_lane.sv
hw/rtl/hebbian_context_error_augment.sv
bench/tb_hebbian_context_error_augment.sv
